### rtl/mgm_pkg.sv
// ----------------------------------------------------------------------------
// mgm_pkg
// Shared widths, fixed-point constants and beat/status types for the
// Mandelbrot grid membership block.
// ----------------------------------------------------------------------------
`default_nettype none

package mgm_pkg;

   // Fixed widths of the beat fields
   localparam int IDX_W = 13;

   // Signed Q8.40 fixed point
   localparam int FX_W      = 48;
   localparam int FRAC_BITS = 40;
   localparam int HALF_W    = FX_W / 2;
   localparam int PP_W      = 2 * (HALF_W + 1);
   localparam int ACC_W     = 2 * FX_W;

   localparam logic signed [FX_W-1:0] FX_FOUR = FX_W'(64'd4 << FRAC_BITS);

   typedef struct packed {
      logic [IDX_W-1:0] pixel_index;
   } req_payload_type;

   typedef struct packed {
      logic in_set;
      logic index_error;
   } rsp_payload_type;

   // Status of a multi-cycle helper unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

`default_nettype wire

### rtl/mgm_stream_if.sv
// ----------------------------------------------------------------------------
// mgm_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mgm_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/mgm_mul.sv
// ----------------------------------------------------------------------------
// mgm_mul
// Shared Q8.40 multiplier: one 25x25 signed partial product per cycle,
// four partials accumulated, result is the full product shifted right by 40
// (floor).
// ----------------------------------------------------------------------------
`default_nettype none

module mgm_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [mgm_pkg::FX_W-1:0]    op_a,
   input  logic signed [mgm_pkg::FX_W-1:0]    op_b,
   output mgm_pkg::unit_sts_type              sts,
   output logic signed [mgm_pkg::FX_W-1:0]    product
);
   import mgm_pkg::*;

   localparam logic [1:0] PART_LAST = 2'd3;

   logic signed [FX_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic                    busy_ff, busy_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    pv_ff, pv_in;
   logic [1:0]              psel_ff, psel_in;
   logic signed [PP_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    done_ff, done_in;
   logic signed [HALF_W:0]  opa_part, opb_part;
   logic signed [ACC_W-1:0] pp_ext;

   // a = ah*2^24 + al, al unsigned, ah signed; partial k uses hi of a when k[1],
   // hi of b when k[0]
   always_comb begin
      opa_part = cnt_ff[1] ? $signed({a_ff[FX_W-1], a_ff[FX_W-1:HALF_W]})
                           : $signed({1'b0, a_ff[HALF_W-1:0]});
      opb_part = cnt_ff[0] ? $signed({b_ff[FX_W-1], b_ff[FX_W-1:HALF_W]})
                           : $signed({1'b0, b_ff[HALF_W-1:0]});
      prod_in  = opa_part * opb_part;

      case (psel_ff)
         2'd0:    pp_ext = ACC_W'(prod_ff);
         2'd1,
         2'd2:    pp_ext = ACC_W'(prod_ff) <<< HALF_W;
         default: pp_ext = ACC_W'(prod_ff) <<< FX_W;
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      pv_in   = busy_ff;
      psel_in = cnt_ff;
      done_in = pv_ff && (psel_ff == PART_LAST);

      if (busy_ff) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == PART_LAST) begin
            busy_in = 1'b0;
         end
      end
      if (pv_ff) begin
         acc_in = acc_ff + pp_ext;
      end
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pv_ff   <= pv_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      psel_ff <= psel_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign sts.busy = busy_ff || pv_ff;
   assign sts.done = done_ff;
   assign product  = acc_ff[FRAC_BITS +: FX_W];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff && !pv_ff)
      else $error("multiplier restarted mid-product");

   a_issue_end: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff == PART_LAST |=> !busy_ff && pv_ff && psel_ff == PART_LAST)
      else $error("last partial not handed to accumulator");

   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      pv_ff && psel_ff == PART_LAST |=> done_ff && !pv_ff)
      else $error("product done not flagged after last partial");

endmodule

`default_nettype wire

### rtl/mgm_split.sv
// ----------------------------------------------------------------------------
// mgm_split
// Splits a flat pixel index into row (reciprocal multiply) in one stage, then
// derives the column (multiply-subtract) and maps both to Q8.40 coordinates
// through a constant table in the next stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mgm_split #(
   parameter int PIXELS_PER_UNIT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mgm_pkg::IDX_W-1:0]       pixel_index,
   output mgm_pkg::unit_sts_type           sts,
   output logic signed [mgm_pkg::FX_W-1:0] cre,
   output logic signed [mgm_pkg::FX_W-1:0] cim
);
   import mgm_pkg::*;

   localparam int SIDE      = 4 * PIXELS_PER_UNIT + 1;
   localparam int HALF      = 2 * PIXELS_PER_UNIT;
   localparam int COORD_W   = $clog2(SIDE);
   localparam int MAG_W     = $clog2(HALF + 1);
   // ceil(2^DIV_SHIFT / SIDE) gives the exact quotient for every IDX_W-bit index
   localparam int DIV_SHIFT = IDX_W + COORD_W;
   localparam int RECIP_W   = IDX_W + 2;
   localparam int PROD_W    = IDX_W + RECIP_W;
   localparam logic [63:0] RECIP_VAL =
      ((64'd1 << DIV_SHIFT) + 64'(SIDE) - 64'd1) / 64'(SIDE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   logic                    step_ff, step_in;
   logic                    look_ff, look_in;
   logic                    done_ff, done_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [COORD_W-1:0]      row_ff, row_in;
   logic signed [FX_W-1:0]  cre_ff, cre_in, cim_ff, cim_in;
   logic [PROD_W-1:0]       quo_prod;
   logic [IDX_W-1:0]        row_base;
   logic [IDX_W-1:0]        col_full;
   logic signed [FX_W-1:0]  coord_tab [HALF+1];
   logic [COORD_W-1:0]      k [2];
   logic [MAG_W-1:0]        mag [2];
   logic signed [FX_W-1:0]  coord [2];

   // |k - 2P| * 2^40 / P, truncated
   for (genvar g = 0; g <= HALF; g++) begin : g_coord_tab
      localparam logic [63:0] TAB_VAL = (64'(g) << FRAC_BITS) / 64'(PIXELS_PER_UNIT);
      assign coord_tab[g] = FX_W'(TAB_VAL);
   end

   always_comb begin
      quo_prod = PROD_W'(idx_ff) * PROD_W'(RECIP);
      row_base = IDX_W'(32'(row_ff) * SIDE);
      col_full = idx_ff - row_base;

      k[0] = col_full[COORD_W-1:0];
      k[1] = row_ff;
      for (int i = 0; i < 2; i++) begin
         if (k[i] >= COORD_W'(HALF)) begin
            mag[i]   = MAG_W'(k[i] - COORD_W'(HALF));
            coord[i] = coord_tab[mag[i]];
         end else begin
            mag[i]   = MAG_W'(COORD_W'(HALF) - k[i]);
            coord[i] = -coord_tab[mag[i]];
         end
      end
   end

   always_comb begin
      step_in = start;
      look_in = step_ff;
      done_in = look_ff;
      idx_in  = idx_ff;
      row_in  = row_ff;
      cre_in  = cre_ff;
      cim_in  = cim_ff;

      if (start) begin
         idx_in = pixel_index;
      end
      if (step_ff) begin
         row_in = quo_prod[DIV_SHIFT +: COORD_W];
      end
      if (look_ff) begin
         cre_in = coord[0];
         cim_in = coord[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
         look_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         look_ff <= look_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      row_ff <= row_in;
      cre_ff <= cre_in;
      cim_ff <= cim_in;
   end

   assign sts.busy = step_ff || look_ff;
   assign sts.done = done_ff;
   assign cre      = cre_ff;
   assign cim      = cim_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !step_ff && !look_ff)
      else $error("index split restarted while busy");

   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      step_ff |=> look_ff && !step_ff)
      else $error("row stage not followed by coordinate lookup");

   // caller only starts with an index inside the grid
   a_in_grid: assert property (@(posedge clock) disable iff (reset)
      look_ff |-> 32'(row_ff) < SIDE && 32'(col_full) < SIDE)
      else $error("column or row outside the grid");

endmodule

`default_nettype wire

### rtl/mandelbrot_grid_membership.sv
// ----------------------------------------------------------------------------
// mandelbrot_grid_membership
// Escape-time membership test over a square pixel grid on [-2,2] x [-2,2].
// Each req beat carries a row-major pixel index; each rsp beat carries in_set
// and index_error for it, one result per request, in order. Items are handled
// one at a time: an index outside the grid is answered directly; otherwise the
// index is split into row and column by a reciprocal multiply, then each
// escape-time step is dominated by the single shared multiplier that builds
// each Q8.40 product from four 25x25 partials (three products per step), plus
// a final magnitude check. At most MAX_ITERATIONS steps are taken. A new req
// beat is taken while the previous rsp beat still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_grid_membership #(
   parameter int PIXELS_PER_UNIT = 16,
   parameter int MAX_ITERATIONS  = 8
) (
   input  logic          clock,
   input  logic          reset,
   mgm_stream_if.sink    req_chan,
   mgm_stream_if.source  rsp_chan
);
   import mgm_pkg::*;

   localparam int SIDE   = 4 * PIXELS_PER_UNIT + 1;
   localparam int CELLS  = SIDE * SIDE;
   localparam int LEFT_W = $clog2(MAX_ITERATIONS + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SPLIT    = 4'd1;
   localparam logic [3:0] S_GO_RR    = 4'd2;
   localparam logic [3:0] S_WAIT_RR  = 4'd3;
   localparam logic [3:0] S_GO_II    = 4'd4;
   localparam logic [3:0] S_WAIT_II  = 4'd5;
   localparam logic [3:0] S_CHECK    = 4'd6;
   localparam logic [3:0] S_GO_RI    = 4'd7;
   localparam logic [3:0] S_WAIT_RI  = 4'd8;
   localparam logic [3:0] S_UPDATE   = 4'd9;
   localparam logic [3:0] S_FINISH   = 4'd10;

   logic [3:0]             state_ff, state_in;
   logic signed [FX_W-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [FX_W-1:0] rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [LEFT_W-1:0]      left_ff, left_in;
   logic                   fin_set_ff, fin_set_in, fin_err_ff, fin_err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_set_ff, rsp_set_in, rsp_err_ff, rsp_err_in;

   logic                   accept;
   logic                   idx_bad;
   logic                   split_start;
   unit_sts_type           split_sts;
   logic signed [FX_W-1:0] cre, cim;
   logic                   mul_start;
   unit_sts_type           mul_sts;
   logic signed [FX_W-1:0] mul_a, mul_b, mul_p;
   logic signed [FX_W:0]   mag_sum;
   logic                   mag_over, mag_under;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign idx_bad        = 32'(req_chan.payload.pixel_index) >= CELLS;
   assign split_start    = accept && !idx_bad;

   mgm_split #(
      .PIXELS_PER_UNIT (PIXELS_PER_UNIT)
   ) u_split (
      .clock       (clock),
      .reset       (reset),
      .start       (split_start),
      .pixel_index (req_chan.payload.pixel_index),
      .sts         (split_sts),
      .cre         (cre),
      .cim         (cim)
   );

   assign mul_start = (state_ff == S_GO_RR) || (state_ff == S_GO_II) ||
                      (state_ff == S_GO_RI);
   assign mul_a     = (state_ff == S_GO_II) ? im_ff : re_ff;
   assign mul_b     = (state_ff == S_GO_RR) ? re_ff : im_ff;

   mgm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .sts     (mul_sts),
      .product (mul_p)
   );

   // squares are floored but never negative, so the sum cannot wrap
   assign mag_sum   = (FX_W+1)'(rr_ff) + (FX_W+1)'(ii_ff);
   assign mag_over  = mag_sum > (FX_W+1)'(FX_FOUR);
   assign mag_under = mag_sum < (FX_W+1)'(FX_FOUR);

   always_comb begin
      state_in     = state_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      ri_in        = ri_ff;
      left_in      = left_ff;
      fin_set_in   = fin_set_ff;
      fin_err_in   = fin_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_set_in   = rsp_set_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (idx_bad) begin
                  fin_set_in = 1'b0;
                  fin_err_in = 1'b1;
                  state_in   = S_FINISH;
               end else begin
                  state_in = S_SPLIT;
               end
            end
         end
         S_SPLIT: begin
            if (split_sts.done) begin
               re_in    = cre;
               im_in    = cim;
               left_in  = LEFT_W'(MAX_ITERATIONS);
               state_in = S_GO_RR;
            end
         end
         S_GO_RR:   state_in = S_WAIT_RR;
         S_WAIT_RR: begin
            if (mul_sts.done) begin
               rr_in    = mul_p;
               state_in = S_GO_II;
            end
         end
         S_GO_II:   state_in = S_WAIT_II;
         S_WAIT_II: begin
            if (mul_sts.done) begin
               ii_in    = mul_p;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (left_ff == '0 || mag_over) begin
               fin_set_in = mag_under;
               fin_err_in = 1'b0;
               state_in   = S_FINISH;
            end else begin
               state_in = S_GO_RI;
            end
         end
         S_GO_RI:   state_in = S_WAIT_RI;
         S_WAIT_RI: begin
            if (mul_sts.done) begin
               ri_in    = mul_p;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            re_in    = rr_ff - ii_ff + cre;
            im_in    = (ri_ff <<< 1) + cim;
            left_in  = left_ff - LEFT_W'(1);
            state_in = S_GO_RR;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_set_in   = fin_set_ff;
               rsp_err_in   = fin_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      re_ff      <= re_in;
      im_ff      <= im_in;
      rr_ff      <= rr_in;
      ii_ff      <= ii_in;
      ri_ff      <= ri_in;
      left_ff    <= left_in;
      fin_set_ff <= fin_set_in;
      fin_err_ff <= fin_err_in;
      rsp_set_ff <= rsp_set_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = '{in_set: rsp_set_ff, index_error: rsp_err_ff};

   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      accept && idx_bad |=> state_ff == S_FINISH && fin_err_ff && !fin_set_ff)
      else $error("out-of-grid index not answered directly");

   a_split_alive: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SPLIT |-> split_sts.busy || split_sts.done)
      else $error("waiting on an idle index split");

   a_mul_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT_RR || state_ff == S_WAIT_II || state_ff == S_WAIT_RI)
      |-> mul_sts.busy || mul_sts.done)
      else $error("waiting on an idle multiplier");

   a_steps_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPDATE |-> left_ff != '0)
      else $error("iteration taken with no steps left");

   a_err_not_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> !rsp_set_ff)
      else $error("in_set raised together with index_error");

endmodule

`default_nettype wire

### dv/mgm_membership_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mgm_membership_checker
// Watches the req and rsp channels of the grid membership block. Every
// accepted req beat is run through a Q8.40 escape-time predictor; every rsp
// beat is compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module mgm_membership_checker #(
   parameter int PIXELS_PER_UNIT = 16,
   parameter int MAX_ITERATIONS  = 8
) (
   input  logic  clock,
   input  logic  reset,
   mgm_stream_if req_chan,
   mgm_stream_if rsp_chan,
   output int    fail_count,
   output int    pending
);
   import mgm_pkg::*;

   localparam int     GRID_SIDE  = 4 * PIXELS_PER_UNIT + 1;
   localparam int     GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam longint FX_UNIT    = 64'sd1 <<< FRAC_BITS;
   localparam longint MAG_LIMIT  = 4 * FX_UNIT;
   localparam longint MAG_CAP    = (64'sd1 <<< 47) - 1;

   typedef struct {
      logic [IDX_W-1:0] pixel;
      rsp_payload_type  verdict;
   } membership_entry_type;

   membership_entry_type awaited_q[$];
   membership_entry_type head;

   // Q8.40 product, floor of the exact value (arithmetic shift of the full product)
   function automatic longint fx_product(longint a, longint b);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] full;
      wa = a;
      wb = b;
      full = wa * wb;
      return longint'(full >>> FRAC_BITS);
   endfunction

   // grid coordinate to Q8.40, truncated toward zero
   function automatic longint grid_to_fx(int k);
      longint offset;
      longint scaled;
      offset = k - 2 * PIXELS_PER_UNIT;
      scaled = ((offset < 0 ? -offset : offset) <<< FRAC_BITS) / PIXELS_PER_UNIT;
      return offset < 0 ? -scaled : scaled;
   endfunction

   function automatic longint sq_magnitude(longint re, longint im);
      longint s;
      s = fx_product(re, re) + fx_product(im, im);
      return s > MAG_CAP ? MAG_CAP : s;
   endfunction

   function automatic rsp_payload_type predict_membership(logic [IDX_W-1:0] idx);
      rsp_payload_type r;
      int              pix;
      int              steps_left;
      longint          c_re, c_im, z_re, z_im, next_re, mag;
      r = '0;
      pix = idx;
      if (pix >= GRID_CELLS) begin
         r.index_error = 1'b1;
         return r;
      end
      c_re = grid_to_fx(pix % GRID_SIDE);
      c_im = grid_to_fx(pix / GRID_SIDE);
      z_re = c_re;
      z_im = c_im;
      steps_left = MAX_ITERATIONS;
      mag = sq_magnitude(z_re, z_im);
      // magnitude exactly 4 keeps iterating
      while (steps_left > 0 && mag <= MAG_LIMIT) begin
         next_re = fx_product(z_re, z_re) - fx_product(z_im, z_im) + c_re;
         z_im = 2 * fx_product(z_re, z_im) + c_im;
         z_re = next_re;
         steps_left--;
         mag = sq_magnitude(z_re, z_im);
      end
      r.in_set = mag < MAG_LIMIT;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t checker: %s", $realtime, msg);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         awaited_q.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            awaited_q.push_back('{req_chan.payload.pixel_index,
                                  predict_membership(req_chan.payload.pixel_index)});
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_q.size() == 0) begin
               report_mismatch($sformatf("rsp beat with nothing outstanding (in_set=%0b err=%0b)",
                                         rsp_chan.payload.in_set,
                                         rsp_chan.payload.index_error));
            end else begin
               head = awaited_q.pop_front();
               if (rsp_chan.payload.in_set !== head.verdict.in_set)
                  report_mismatch($sformatf("pixel %0d in_set expected %0b got %0b",
                                            head.pixel, head.verdict.in_set,
                                            rsp_chan.payload.in_set));
               if (rsp_chan.payload.index_error !== head.verdict.index_error)
                  report_mismatch($sformatf("pixel %0d index_error expected %0b got %0b",
                                            head.pixel, head.verdict.index_error,
                                            rsp_chan.payload.index_error));
            end
         end
      end
      pending <= awaited_q.size();
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel indexes into the grid membership block with random gaps and
// random rsp back-pressure: a directed set of corner, center and boundary
// pixels first, then random pixels mostly inside the grid. Checking is done
// by the membership checker instantiated beside the block.
// ----------------------------------------------------------------------------

module testbench;
   import mgm_pkg::*;

   localparam int PIXELS_PER_UNIT = 16;
   localparam int MAX_ITERATIONS  = 8;
   localparam int GRID_SIDE       = 4 * PIXELS_PER_UNIT + 1;
   localparam int GRID_CELLS      = GRID_SIDE * GRID_SIDE;
   localparam int CENTER          = 2 * PIXELS_PER_UNIT;
   localparam int RANDOM_PIXELS   = 1000;
   localparam int DRAIN_CYCLES    = 300;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   calm_req;
   bit   calm_rsp;
   int   rsp_hold;
   int   rsp_draw;

   mgm_stream_if #(.payload_type(req_payload_type)) req_chan ();
   mgm_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   mandelbrot_grid_membership #(
      .PIXELS_PER_UNIT (PIXELS_PER_UNIT),
      .MAX_ITERATIONS  (MAX_ITERATIONS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mgm_membership_checker #(
      .PIXELS_PER_UNIT (PIXELS_PER_UNIT),
      .MAX_ITERATIONS  (MAX_ITERATIONS)
   ) membership_check (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic int grid_pixel(int col, int row);
      return row * GRID_SIDE + col;
   endfunction

   // rsp back-pressure: after each beat, ready drops for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         if ($urandom_range(0, 39) == 0)
            calm_rsp = ~calm_rsp;
         rsp_draw = draw_wait(calm_rsp);
         rsp_chan.ready <= (rsp_draw == 0);
         rsp_hold <= rsp_draw;
      end else if (rsp_hold != 0) begin
         rsp_chan.ready <= (rsp_hold == 1);
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_pixel(int idx);
      int gap;
      if ($urandom_range(0, 39) == 0)
         calm_req = ~calm_req;
      gap = draw_wait(calm_req);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload.pixel_index <= IDX_W'(idx);
      do @(posedge clock); while (!req_chan.ready);
   endtask

   initial begin
      int directed[$];
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      calm_req = 1'b0;
      calm_rsp = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      directed = '{
         0,                                      // corner (-2,-2), escapes at once
         GRID_CELLS - 1,                         // last pixel of the grid
         GRID_CELLS,                             // first index past the grid
         (1 << IDX_W) - 1,                       // all index bits set
         grid_pixel(CENTER, CENTER),             // origin, stays bounded
         grid_pixel(0, CENTER),                  // c = -2: magnitude sits at 4
         grid_pixel(GRID_SIDE - 1, CENTER),      // c = +2
         grid_pixel(CENTER, 0),                  // c = -2i
         grid_pixel(CENTER, GRID_SIDE - 1),      // c = +2i
         grid_pixel(GRID_SIDE - 1, 0),
         grid_pixel(0, GRID_SIDE - 1),
         grid_pixel(CENTER - PIXELS_PER_UNIT, CENTER),      // c = -1, period-2 orbit
         grid_pixel(CENTER + PIXELS_PER_UNIT / 4, CENTER),  // c = 0.25, cusp
         grid_pixel(CENTER, CENTER + PIXELS_PER_UNIT),      // c = i
         grid_pixel(CENTER + 5, CENTER + 9),
         grid_pixel(CENTER - 12, CENTER - 10),
         GRID_SIDE,
         GRID_SIDE - 1,
         4096,
         2048,
         6000
      };
      foreach (directed[i])
         send_pixel(directed[i]);

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         if ($urandom_range(0, 4) != 0)
            send_pixel($urandom_range(0, GRID_CELLS - 1));
         else
            send_pixel($urandom_range(GRID_CELLS, (1 << IDX_W) - 1));
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/mgm_pkg.sv
rtl/mgm_stream_if.sv
rtl/mgm_mul.sv
rtl/mgm_split.sv
rtl/mandelbrot_grid_membership.sv
dv/mgm_membership_checker.sv
dv/testbench.sv
